// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file gbt_checker.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, masked during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds while enabled
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== design/gbt_pkg.sv =====
// Shared types and codes for the graph traversal block.
// No dependencies.
package gbt_pkg;

    localparam int NODE_W         = 6;
    localparam int NODE_COUNT_DEF = 64;
    localparam int EDGE_CAP_DEF   = 256;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_BFS  = 2'd1;
    localparam logic [1:0] OP_DFS  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] KIND_VISIT  = 2'd0;
    localparam logic [1:0] KIND_STORED = 2'd1;
    localparam logic [1:0] KIND_FULL   = 2'd2;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_ADD_RD,
        DP_ADD_LINK,
        DP_ADD_NEW,
        DP_ADD_SWAP,
        DP_RES_OK,
        DP_RES_FULL,
        DP_INIT_B,
        DP_INIT_D,
        DP_B_POP,
        DP_B_HEAD,
        DP_EMIT,
        DP_LOADH,
        DP_SCAN,
        DP_B_EDGE,
        DP_D_EDGE,
        DP_D_POP,
        DP_D_POPLD,
        DP_FLUSH
    } dp_op_t;

    typedef struct packed {
        logic full;
        logic more_edge;
        logic out_free;
        logic emit_ok;
        logic cur_valid;
        logic queue_more;
        logic push_ok;
        logic sp_one;
    } ctrl_status_t;

endpackage

// ===== design/gbt_in_if.sv =====
// Request channel: one add-edge or traversal request per handshake.
// Depends on gbt_pkg.
interface gbt_in_if import gbt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic              bidirectional;

    modport source (output valid, opcode, from_node, to_node, bidirectional, input ready);
    modport sink   (input valid, opcode, from_node, to_node, bidirectional, output ready);
endinterface

// ===== design/gbt_out_if.sv =====
// Result channel: visited nodes and add-edge outcomes.
// Depends on gbt_pkg.
interface gbt_out_if import gbt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] visited_node;
    logic [1:0]        result_kind;
    logic              last;

    modport source (output valid, visited_node, result_kind, last, input ready);
    modport sink   (input valid, visited_node, result_kind, last, output ready);
endinterface

// ===== design/graph_bfs_dfs_traversal.sv =====
// Directed graph store with breadth-first and depth-first search. Each request
// is accepted only when the previous one has been fully worked off. Adding an
// edge runs a capacity check and, if there is room, one tail read, one link
// write and one edge write per edge on single-port memories, with a swap of
// the two end nodes between edges when bidirectional, and the result write.
// A traversal is paced by the pointer chase through the edge memory, one
// edge read at a time; results stalled downstream hold the sequencer. No
// clearing pass is needed after reset.
// Depends on gbt_pkg, gbt_in_if, gbt_out_if, gbt_ctrl and gbt_dp.
module graph_bfs_dfs_traversal import gbt_pkg::*;
#(
    parameter int NODE_COUNT    = NODE_COUNT_DEF,
    parameter int EDGE_CAPACITY = EDGE_CAP_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    gbt_in_if.sink    request,
    gbt_out_if.source result
);

    ctrl_status_t status;
    dp_op_t       dp_op;

    gbt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_opcode (request.opcode),
        .in_ready  (request.ready),
        .status    (status),
        .dp_op     (dp_op)
    );

    gbt_dp #(
        .NODE_COUNT    (NODE_COUNT),
        .EDGE_CAPACITY (EDGE_CAPACITY)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_op         (dp_op),
        .status        (status),
        .from_node     (request.from_node),
        .to_node       (request.to_node),
        .bidirectional (request.bidirectional),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .out_node      (result.visited_node),
        .out_kind      (result.result_kind),
        .out_last      (result.last)
    );

endmodule

// ===== design/gbt_ctrl.sv =====
// Sequencer for edge insertion and breadth/depth-first traversal.
// Depends on gbt_pkg; drives the datapath by one command per cycle.
module gbt_ctrl import gbt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [1:0]   in_opcode,
    output logic         in_ready,
    input  ctrl_status_t status,
    output dp_op_t       dp_op
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_CHK,
        S_A_RD,
        S_A_LINK,
        S_A_NEW,
        S_A_SWAP,
        S_A_RES,
        S_A_REJ,
        S_B_INIT,
        S_B_POP,
        S_B_HEAD,
        S_B_EMIT,
        S_B_LOADH,
        S_B_SCAN,
        S_B_EDGE,
        S_D_INIT,
        S_D_LOADH,
        S_D_TOP,
        S_D_EDGE,
        S_D_EMIT,
        S_D_POPLD,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    assign in_ready = ready_reg;

    always_comb
    begin
        state_next = state_reg;
        dp_op      = DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    dp_op = DP_LATCH;
                    case (in_opcode)
                        OP_ADD:  state_next = S_A_CHK;
                        OP_BFS:  state_next = S_B_INIT;
                        OP_DFS:  state_next = S_D_INIT;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_A_CHK:  state_next = status.full ? S_A_REJ : S_A_RD;
            S_A_RD:
            begin
                dp_op      = DP_ADD_RD;
                state_next = S_A_LINK;
            end
            S_A_LINK:
            begin
                dp_op      = DP_ADD_LINK;
                state_next = S_A_NEW;
            end
            S_A_NEW:
            begin
                dp_op      = DP_ADD_NEW;
                state_next = status.more_edge ? S_A_SWAP : S_A_RES;
            end
            S_A_SWAP:
            begin
                dp_op      = DP_ADD_SWAP;
                state_next = S_A_RD;
            end
            S_A_RES:
            begin
                if (status.out_free)
                begin
                    dp_op      = DP_RES_OK;
                    state_next = S_IDLE;
                end
            end
            S_A_REJ:
            begin
                if (status.out_free)
                begin
                    dp_op      = DP_RES_FULL;
                    state_next = S_IDLE;
                end
            end
            S_B_INIT:
            begin
                dp_op      = DP_INIT_B;
                state_next = S_B_POP;
            end
            S_B_POP:
            begin
                if (status.queue_more)
                begin
                    dp_op      = DP_B_POP;
                    state_next = S_B_HEAD;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_B_HEAD:
            begin
                dp_op      = DP_B_HEAD;
                state_next = S_B_EMIT;
            end
            S_B_EMIT:
            begin
                if (status.emit_ok)
                begin
                    dp_op      = DP_EMIT;
                    state_next = S_B_LOADH;
                end
            end
            S_B_LOADH:
            begin
                dp_op      = DP_LOADH;
                state_next = S_B_SCAN;
            end
            S_B_SCAN:
            begin
                if (status.cur_valid)
                begin
                    dp_op      = DP_SCAN;
                    state_next = S_B_EDGE;
                end
                else
                begin
                    state_next = S_B_POP;
                end
            end
            S_B_EDGE:
            begin
                dp_op      = DP_B_EDGE;
                state_next = S_B_SCAN;
            end
            S_D_INIT:
            begin
                dp_op      = DP_INIT_D;
                state_next = S_D_LOADH;
            end
            S_D_LOADH:
            begin
                dp_op      = DP_LOADH;
                state_next = S_D_TOP;
            end
            S_D_TOP:
            begin
                if (status.cur_valid)
                begin
                    dp_op      = DP_SCAN;
                    state_next = S_D_EDGE;
                end
                else
                begin
                    dp_op      = DP_D_POP;
                    state_next = status.sp_one ? S_FLUSH : S_D_POPLD;
                end
            end
            S_D_EDGE:
            begin
                dp_op      = DP_D_EDGE;
                state_next = status.push_ok ? S_D_EMIT : S_D_TOP;
            end
            S_D_EMIT:
            begin
                if (status.emit_ok)
                begin
                    dp_op      = DP_EMIT;
                    state_next = S_D_LOADH;
                end
            end
            S_D_POPLD:
            begin
                dp_op      = DP_D_POPLD;
                state_next = S_D_TOP;
            end
            S_FLUSH:
            begin
                if (status.out_free)
                begin
                    dp_op      = DP_FLUSH;
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ===== design/gbt_dp.sv =====
// Datapath: adjacency memories, traversal queue and stack, result register.
// Depends on gbt_pkg; commanded by gbt_ctrl.
module gbt_dp import gbt_pkg::*;
#(
    parameter int NODE_COUNT    = NODE_COUNT_DEF,
    parameter int EDGE_CAPACITY = EDGE_CAP_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_op_t            dp_op,
    output ctrl_status_t      status,
    input  logic [NODE_W-1:0] from_node,
    input  logic [NODE_W-1:0] to_node,
    input  logic              bidirectional,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NODE_W-1:0] out_node,
    output logic [1:0]        out_kind,
    output logic              out_last
);

    localparam int NCW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CW  = $clog2(NODE_COUNT + 1);
    localparam int EW  = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
    localparam int UW  = EW + 2;

    // node id reduction table, folded at elaboration
    logic [NODE_W-1:0] mod_tab [1 << NODE_W];
    for (genvar i = 0; i < (1 << NODE_W); i++)
    begin : g_mod
        assign mod_tab[i] = NODE_W'(i % NODE_COUNT);
    end

    logic [EW-1:0]     head_mem   [NODE_COUNT];
    logic [EW-1:0]     tail_mem   [NODE_COUNT];
    logic [NODE_W-1:0] target_mem [EDGE_CAPACITY];
    logic [EW:0]       next_mem   [EDGE_CAPACITY];
    logic [NODE_W-1:0] queue_mem  [NODE_COUNT];
    logic [EW:0]       stack_mem  [NODE_COUNT];

    logic [EW-1:0]     head_q, tail_q;
    logic [NODE_W-1:0] target_q, queue_q;
    logic [EW:0]       next_q, stack_q;

    logic [NODE_W-1:0] a_reg, b_reg, node_reg, pend_node_reg;
    logic              bidir_reg;
    logic [EW:0]       cur_reg;
    logic [NODE_W-1:0] out_node_reg;
    logic [1:0]        out_kind_reg;
    logic              out_last_reg;

    logic [EW:0]           used_reg;
    logic [NODE_COUNT-1:0] head_valid_reg, visited_reg;
    logic [CW-1:0]         rd_reg, wr_reg, sp_reg, n_reg;
    logic                  pend_valid_reg, out_valid_reg, second_reg;

    logic              out_free;
    logic              out_load;
    logic [UW-1:0]     need;
    logic [NCW-1:0]    a_idx, tgt_idx, node_idx;
    logic [EW-1:0]     used_idx, cur_idx;
    logic              tgt_new, b_enq, d_push;
    logic [CW-1:0]     sp_dec2;

    assign a_idx    = a_reg[NCW-1:0];
    assign tgt_idx  = target_q[NCW-1:0];
    assign node_idx = node_reg[NCW-1:0];
    assign used_idx = used_reg[EW-1:0];
    assign cur_idx  = cur_reg[EW-1:0];
    assign sp_dec2  = sp_reg - CW'(2);

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (dp_op == DP_RES_OK) || (dp_op == DP_RES_FULL) || (dp_op == DP_FLUSH)
                      || ((dp_op == DP_EMIT) && pend_valid_reg);
    assign need     = bidir_reg ? UW'(2) : UW'(1);
    assign tgt_new  = !visited_reg[tgt_idx];
    assign b_enq    = tgt_new && (wr_reg < CW'(NODE_COUNT));
    assign d_push   = tgt_new && (sp_reg < CW'(NODE_COUNT)) && (n_reg < CW'(NODE_COUNT));

    always_comb
    begin
        status.full       = (UW'(used_reg) + need) > UW'(EDGE_CAPACITY);
        status.more_edge  = bidir_reg && !second_reg;
        status.out_free   = out_free;
        status.emit_ok    = !pend_valid_reg || out_free;
        status.cur_valid  = cur_reg[EW];
        status.queue_more = (rd_reg < wr_reg) && (n_reg < CW'(NODE_COUNT));
        status.push_ok    = d_push;
        status.sp_one     = (sp_reg == CW'(1));
    end

    assign out_valid = out_valid_reg;
    assign out_node  = out_node_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

    // memories and payload registers
    always_ff @(posedge clk)
    begin
        case (dp_op)
            DP_LATCH:
            begin
                a_reg     <= mod_tab[from_node];
                b_reg     <= mod_tab[to_node];
                bidir_reg <= bidirectional;
            end
            DP_ADD_RD:   tail_q <= tail_mem[a_idx];
            DP_ADD_LINK:
            begin
                if (head_valid_reg[a_idx])
                begin
                    next_mem[tail_q] <= {1'b1, used_idx};
                end
            end
            DP_ADD_NEW:
            begin
                target_mem[used_idx] <= b_reg;
                next_mem[used_idx]   <= '0;
                tail_mem[a_idx]      <= used_idx;
                if (!head_valid_reg[a_idx])
                begin
                    head_mem[a_idx] <= used_idx;
                end
            end
            DP_ADD_SWAP:
            begin
                a_reg <= b_reg;
                b_reg <= a_reg;
            end
            DP_RES_OK:
            begin
                out_node_reg <= '0;
                out_kind_reg <= KIND_STORED;
                out_last_reg <= 1'b1;
            end
            DP_RES_FULL:
            begin
                out_node_reg <= '0;
                out_kind_reg <= KIND_FULL;
                out_last_reg <= 1'b1;
            end
            DP_INIT_B:   queue_mem[0] <= a_reg;
            DP_INIT_D:
            begin
                head_q        <= head_mem[a_idx];
                node_reg      <= a_reg;
                pend_node_reg <= a_reg;
            end
            DP_B_POP:    queue_q <= queue_mem[rd_reg[NCW-1:0]];
            DP_B_HEAD:
            begin
                node_reg <= queue_q;
                head_q   <= head_mem[queue_q[NCW-1:0]];
            end
            DP_EMIT:
            begin
                // the first breadth-first node only moves into the pending slot
                if (pend_valid_reg)
                begin
                    out_node_reg <= pend_node_reg;
                    out_kind_reg <= KIND_VISIT;
                    out_last_reg <= 1'b0;
                end
                pend_node_reg <= node_reg;
            end
            DP_LOADH:    cur_reg <= {head_valid_reg[node_idx], head_q};
            DP_SCAN:
            begin
                target_q <= target_mem[cur_idx];
                next_q   <= next_mem[cur_idx];
            end
            DP_B_EDGE:
            begin
                cur_reg <= next_q;
                if (b_enq)
                begin
                    queue_mem[wr_reg[NCW-1:0]] <= target_q;
                end
            end
            DP_D_EDGE:
            begin
                cur_reg <= next_q;
                if (d_push)
                begin
                    head_q   <= head_mem[tgt_idx];
                    node_reg <= target_q;
                    stack_mem[sp_dec2[NCW-1:0] + NCW'(1)] <= next_q;
                end
            end
            DP_D_POP:
            begin
                if (sp_reg > CW'(1))
                begin
                    stack_q <= stack_mem[sp_dec2[NCW-1:0]];
                end
            end
            DP_D_POPLD:  cur_reg <= stack_q;
            DP_FLUSH:
            begin
                out_node_reg <= pend_node_reg;
                out_kind_reg <= KIND_VISIT;
                out_last_reg <= 1'b1;
            end
            default:     cur_reg <= cur_reg;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            head_valid_reg <= '0;
            visited_reg    <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            sp_reg         <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            second_reg     <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (dp_op)
                DP_LATCH:    second_reg <= 1'b0;
                DP_ADD_NEW:
                begin
                    head_valid_reg[a_idx] <= 1'b1;
                    used_reg              <= used_reg + (EW + 1)'(1);
                end
                DP_ADD_SWAP: second_reg <= 1'b1;
                DP_INIT_B:
                begin
                    visited_reg    <= NODE_COUNT'(1) << a_idx;
                    rd_reg         <= '0;
                    wr_reg         <= CW'(1);
                    n_reg          <= '0;
                    pend_valid_reg <= 1'b0;
                end
                DP_INIT_D:
                begin
                    visited_reg    <= NODE_COUNT'(1) << a_idx;
                    sp_reg         <= CW'(1);
                    n_reg          <= CW'(1);
                    pend_valid_reg <= 1'b1;
                end
                DP_B_POP:    rd_reg <= rd_reg + CW'(1);
                DP_EMIT:
                begin
                    pend_valid_reg <= 1'b1;
                    // depth-first counts the node when it is pushed
                    if (sp_reg == '0)
                    begin
                        n_reg <= n_reg + CW'(1);
                    end
                end
                DP_B_EDGE:
                begin
                    if (b_enq)
                    begin
                        visited_reg[tgt_idx] <= 1'b1;
                        wr_reg               <= wr_reg + CW'(1);
                    end
                end
                DP_D_EDGE:
                begin
                    if (d_push)
                    begin
                        visited_reg[tgt_idx] <= 1'b1;
                        sp_reg               <= sp_reg + CW'(1);
                        n_reg                <= n_reg + CW'(1);
                    end
                end
                DP_D_POP:    sp_reg <= sp_reg - CW'(1);
                DP_FLUSH:
                begin
                    pend_valid_reg <= 1'b0;
                    sp_reg         <= '0;
                end
                default:     second_reg <= second_reg;
            endcase
        end
    end

endmodule

// ===== design/gbt_checker.sv =====
// Port-level checks on the traversal block, bound to the top level.
// Depends on gbt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gbt_checker import gbt_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [NODE_W-1:0] res_node,
    input logic [1:0]        res_kind,
    input logic              res_last
);

    `ASSERT_CLK(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_node) && $stable(res_kind) && $stable(res_last), "result changed while stalled")
    `ASSERT_CLK(a_add_last, res_valid && res_kind != KIND_VISIT |-> res_last && res_node == '0, "add-edge result malformed")
    `ASSERT_NEVER(a_kind_code, res_valid && res_kind > KIND_FULL, "unknown result kind")
    `ASSERT_CLK(a_node_range, res_valid && res_kind == KIND_VISIT |-> int'(res_node) < NODE_COUNT, "visited node out of range")

endmodule

bind graph_bfs_dfs_traversal gbt_checker #(.NODE_COUNT(NODE_COUNT)) u_gbt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_node  (result.visited_node),
    .res_kind  (result.result_kind),
    .res_last  (result.last)
);

// ===== verif/gbt_tb_pkg.sv =====
`timescale 1ns / 1ps
// Request and result record types used by the graph traversal testbench.
// Depends on gbt_pkg.
package gbt_tb_pkg;
    import gbt_pkg::*;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic              bidirectional;
    } gbt_req_t;

    typedef struct packed {
        logic [NODE_W-1:0] visited_node;
        logic [1:0]        result_kind;
        logic              last;
    } gbt_res_t;
endpackage

// ===== verif/tb_graph_bfs_dfs_traversal.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for graph_bfs_dfs_traversal: directed and random requests,
// a behavioural graph predictor and an in-order result scoreboard.
// Depends on gbt_pkg, gbt_tb_pkg, gbt_in_if, gbt_out_if and the block itself.
module tb_graph_bfs_dfs_traversal;
    import gbt_pkg::*;
    import gbt_tb_pkg::*;

    localparam int NODES     = 64;
    localparam int EDGE_CAP  = 256;
    localparam int WDOG_MAX  = 4000;

    logic clk;
    logic rst_n;

    gbt_in_if  req_ch ();
    gbt_out_if res_ch ();

    graph_bfs_dfs_traversal dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch.sink),
        .result  (res_ch.source)
    );

    // predictor state
    logic          head_ok [NODES];
    int            head_ix [NODES];
    int            tail_ix [NODES];
    int            edge_dst [EDGE_CAP];
    logic          next_ok [EDGE_CAP];
    int            next_ix [EDGE_CAP];
    int            edges_used;

    gbt_req_t      pending_reqs[$];
    gbt_res_t      expected_results[$];
    int            mismatches;
    logic          stim_done;
    logic          drain_hold;
    logic          calm;
    int            send_gap;
    int            recv_gap;
    int            quiet_cycles;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    function automatic void add_req(input gbt_req_t q);
        pending_reqs = {pending_reqs, q};
    endfunction

    function automatic void add_expected(input gbt_res_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic void link_edge(input int a, input int b);
        edge_dst[edges_used] = b;
        next_ok[edges_used]  = 1'b0;
        if (head_ok[a])
        begin
            next_ok[tail_ix[a]] = 1'b1;
            next_ix[tail_ix[a]] = edges_used;
        end
        else
        begin
            head_ok[a] = 1'b1;
            head_ix[a] = edges_used;
        end
        tail_ix[a] = edges_used;
        edges_used++;
    endfunction

    function automatic void push_visit(input int n);
        gbt_res_t r;
        r.visited_node = n[NODE_W-1:0];
        r.result_kind  = KIND_VISIT;
        r.last         = 1'b0;
        add_expected(r);
    endfunction

    // works out the results of one accepted request
    function automatic void predict_request(input gbt_req_t q);
        gbt_res_t r;
        logic     seen [NODES];
        int       fifo[$];
        int       stk_node[$];
        logic     stk_ok[$];
        int       stk_e[$];
        int       a, b, n, e, nb, cnt, top;
        logic     have;
        a = q.from_node % NODES;
        b = q.to_node % NODES;
        if (q.opcode == OP_NONE)
            return;
        if (q.opcode == OP_ADD)
        begin
            r.visited_node = '0;
            r.last         = 1'b1;
            if (edges_used + (q.bidirectional ? 2 : 1) > EDGE_CAP)
                r.result_kind = KIND_FULL;
            else
            begin
                link_edge(a, b);
                if (q.bidirectional)
                    link_edge(b, a);
                r.result_kind = KIND_STORED;
            end
            add_expected(r);
            return;
        end
        foreach (seen[i])
            seen[i] = 1'b0;
        cnt = 0;
        seen[a] = 1'b1;
        if (q.opcode == OP_BFS)
        begin
            fifo = {fifo, a};
            while (fifo.size() > 0 && cnt < NODES)
            begin
                n = fifo.pop_front();
                push_visit(n);
                cnt++;
                have = head_ok[n];
                e = head_ix[n];
                while (have)
                begin
                    nb = edge_dst[e];
                    if (!seen[nb])
                    begin
                        seen[nb] = 1'b1;
                        fifo = {fifo, nb};
                    end
                    have = next_ok[e];
                    e = next_ix[e];
                end
            end
        end
        else
        begin
            push_visit(a);
            stk_node = {stk_node, a};
            stk_ok   = {stk_ok, head_ok[a]};
            stk_e    = {stk_e, head_ix[a]};
            while (stk_node.size() > 0)
            begin
                top = stk_node.size() - 1;
                if (stk_ok[top])
                begin
                    e = stk_e[top];
                    nb = edge_dst[e];
                    stk_ok[top] = next_ok[e];
                    stk_e[top] = next_ix[e];
                    if (!seen[nb])
                    begin
                        seen[nb] = 1'b1;
                        push_visit(nb);
                        stk_node = {stk_node, nb};
                        stk_ok   = {stk_ok, head_ok[nb]};
                        stk_e    = {stk_e, head_ix[nb]};
                    end
                end
                else
                begin
                    void'(stk_node.pop_back());
                    void'(stk_ok.pop_back());
                    void'(stk_e.pop_back());
                end
            end
        end
        r = expected_results[$];
        r.last = 1'b1;
        expected_results[$] = r;
    endfunction

    function automatic gbt_req_t make_req(input logic [1:0] op, input int f, input int t,
                                          input logic bd);
        gbt_req_t q;
        q.opcode        = op;
        q.from_node     = f[NODE_W-1:0];
        q.to_node       = t[NODE_W-1:0];
        q.bidirectional = bd;
        return q;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.opcode        <= OP_ADD;
            req_ch.from_node     <= '0;
            req_ch.to_node       <= '0;
            req_ch.bidirectional <= 1'b0;
            send_gap             <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predict_request({req_ch.opcode, req_ch.from_node, req_ch.to_node,
                                 req_ch.bidirectional});
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap     <= send_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !drain_hold)
                begin
                    gbt_req_t q;
                    q = pending_reqs.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.opcode        <= q.opcode;
                    req_ch.from_node     <= q.from_node;
                    req_ch.to_node       <= q.to_node;
                    req_ch.bidirectional <= q.bidirectional;
                    if (!calm && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 16);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_gap     <= 0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                gbt_res_t got, want;
                got = {res_ch.visited_node, res_ch.result_kind, res_ch.last};
                if (expected_results.size() == 0)
                    report($sformatf("unexpected result %p", got));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.visited_node !== want.visited_node)
                        report($sformatf("visited_node %0d, expected %0d",
                                         got.visited_node, want.visited_node));
                    if (got.result_kind !== want.result_kind)
                        report($sformatf("result_kind %0d, expected %0d",
                                         got.result_kind, want.result_kind));
                    if (got.last !== want.last)
                        report($sformatf("last %0b, expected %0b", got.last, want.last));
                end
            end
            if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (recv_gap > 0)
            begin
                recv_gap     <= recv_gap - 1;
                res_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                recv_gap     <= $urandom_range(0, 15);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_random(input int count, input int span);
        int k, f, t;
        logic bd;
        for (k = 0; k < count; k++)
        begin
            f  = $urandom_range(0, span);
            t  = $urandom_range(0, span);
            bd = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: add_req(make_req(OP_ADD, f, t, bd));
                5, 6:          add_req(make_req(OP_BFS, f, t, bd));
                7, 8:          add_req(make_req(OP_DFS, f, t, bd));
                default:       add_req(make_req(OP_NONE, f, t, bd));
            endcase
        end
    endtask

    initial
    begin
        int k;
        foreach (head_ok[i])
            head_ok[i] = 1'b0;
        edges_used = 0;
        mismatches = 0;
        stim_done  = 1'b0;
        drain_hold = 1'b0;
        calm       = 1'b0;
        rst_n      = 1'b0;

        // traversals of an empty graph, single-node lists, self loop both ways
        add_req(make_req(OP_BFS, 63, 0, 1'b0));
        add_req(make_req(OP_DFS, 0, 63, 1'b1));
        add_req(make_req(OP_ADD, 0, 63, 1'b0));
        add_req(make_req(OP_ADD, 63, 0, 1'b1));
        add_req(make_req(OP_ADD, 5, 5, 1'b1));
        add_req(make_req(OP_ADD, 0, 5, 1'b0));
        add_req(make_req(OP_ADD, 5, 42, 1'b1));
        add_req(make_req(OP_NONE, 21, 42, 1'b1));
        add_req(make_req(OP_BFS, 0, 0, 1'b0));
        add_req(make_req(OP_DFS, 0, 21, 1'b0));
        add_req(make_req(OP_BFS, 42, 0, 1'b1));
        add_req(make_req(OP_DFS, 5, 0, 1'b0));
        add_req(make_req(OP_DFS, 63, 63, 1'b1));
        // a bidirectional chain linking every ninth node from 0 to 63
        for (k = 0; k < 7; k++)
            add_req(make_req(OP_ADD, k * 9, k * 9 + 9, 1'b1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        queue_random(25, 63);
        wait (pending_reqs.size() == 0);
        // hold the sender until the block has caught up
        drain_hold = 1'b1;
        wait (expected_results.size() == 0 && !req_ch.valid);
        repeat (10) @(posedge clk);
        drain_hold = 1'b0;

        queue_random(25, 63);
        // fill the edge memory, then try single and double adds against it
        for (k = 0; k < 117; k++)
            add_req(make_req(OP_ADD, $urandom_range(0, 63),
                             $urandom_range(0, 63), 1'b1));
        add_req(make_req(OP_ADD, 1, 2, 1'b1));
        add_req(make_req(OP_ADD, 2, 1, 1'b0));
        queue_random(10, 63);
        wait (pending_reqs.size() == 0);

        calm = 1'b1;
        queue_random(15, 63);
        wait (pending_reqs.size() == 0 && !req_ch.valid);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== graph_bfs_dfs_traversal.f =====
+incdir+design
design/gbt_pkg.sv
design/gbt_in_if.sv
design/gbt_out_if.sv
design/gbt_ctrl.sv
design/gbt_dp.sv
design/graph_bfs_dfs_traversal.sv
design/gbt_checker.sv
verif/gbt_tb_pkg.sv
verif/tb_graph_bfs_dfs_traversal.sv
